### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RAST_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define RAST_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);

`endif

### design/rast_pkg.sv
`default_nettype none

package rast_pkg;

    localparam int TOTAL_W      = 26;
    localparam int FILL_W       = 16;
    localparam int IDX_W        = 10;
    localparam int N_LEAVES_DEF = 1024;

    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_SUM    = 1'b1;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  range_lo;
        logic [IDX_W-1:0]  range_hi;
        logic [FILL_W-1:0] fill_value;
    } req_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] range_total;
        logic               bad_range;
    } rsp_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [FILL_W-1:0]  fill;
        logic               pend;
    } node_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT_RD,
        ST_ROOT_FIN,
        ST_RD_P,
        ST_RD_L,
        ST_RD_R,
        ST_WR_L,
        ST_WR_R,
        ST_WR_P,
        ST_UP_RL,
        ST_UP_RR,
        ST_UP_WR,
        ST_DONE
    } walk_state_t;

endpackage

`default_nettype wire

### design/rast_node_mem.sv
`default_nettype none

module rast_node_mem #(
    parameter int DEPTH = 4 * rast_pkg::N_LEAVES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire rast_pkg::mem_ctl_t mem_ctl,
    input  wire logic [AW-1:0]     rd_addr,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire rast_pkg::node_t   wr_data,
    output rast_pkg::node_t        rd_data
);

    rast_pkg::node_t node_mem [DEPTH];
    rast_pkg::node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/rast_walk.sv
`default_nettype none

`include "assert_macros.svh"

module rast_walk #(
    parameter int N_LEAVES = rast_pkg::N_LEAVES_DEF,
    parameter int KW       = $clog2(4 * N_LEAVES)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire rast_pkg::req_t     req,
    output logic                    done_valid,
    input  wire logic               done_stall,
    output rast_pkg::rsp_t          done,
    output rast_pkg::mem_ctl_t      mem_ctl,
    output logic [KW-1:0]           rd_addr,
    output logic [KW-1:0]           wr_addr,
    output rast_pkg::node_t         wr_data,
    input  wire rast_pkg::node_t    rd_data
);

    localparam int IW         = $clog2(N_LEAVES);
    localparam int POSW       = ((IW > rast_pkg::IDX_W) ? IW : rast_pkg::IDX_W) + 1;
    localparam int TREE_NODES = 4 * N_LEAVES;
    localparam int LEVELS     = IW + 1;
    localparam int STK_D      = 2 * LEVELS;
    localparam int SIW        = $clog2(STK_D);
    localparam int SPW        = $clog2(STK_D + 1);
    localparam int PW         = POSW + rast_pkg::FILL_W;

    rast_pkg::walk_state_t state_reg, state_next;

    logic                         func_reg;
    logic [POSW-1:0]              lo_reg;
    logic [POSW-1:0]              hi_reg;
    logic [rast_pkg::FILL_W-1:0]  v_reg;
    logic                         bad_reg;
    logic [rast_pkg::TOTAL_W-1:0] acc_reg;
    rast_pkg::node_t              p_reg;
    rast_pkg::node_t              l_reg;
    logic [KW-1:0]                fr_k_reg [2];
    logic [POSW-1:0]              fr_s_reg [2];
    logic [POSW-1:0]              fr_e_reg [2];
    logic                         fr_two_reg;
    logic                         cur_reg;
    logic [KW-1:0]                nf_k_reg [2];
    logic [POSW-1:0]              nf_s_reg [2];
    logic [POSW-1:0]              nf_e_reg [2];
    logic [1:0]                   nf_cnt_reg;
    logic [KW-1:0]                stk_reg [STK_D];
    logic [SPW-1:0]               sp_reg;
    logic [KW-1:0]                clr_reg;

    logic [POSW-1:0] in_lo;
    logic [POSW-1:0] in_hi;
    logic            in_bad;
    logic            in_root_full;
    logic            accept;

    logic [KW-1:0]   cur_k;
    logic [POSW-1:0] cur_s;
    logic [POSW-1:0] cur_e;
    logic [POSW-1:0] mid;
    logic [KW-1:0]   lk;
    logic [KW-1:0]   rk;
    logic [KW-1:0]   ch_k;
    logic [POSW-1:0] ch_s;
    logic [POSW-1:0] ch_e;
    rast_pkg::node_t ch_in;
    rast_pkg::node_t ch_new;
    logic            ch_full;
    logic            ch_over;
    logic            ch_part;
    logic            is_assign;
    logic [POSW-1:0]             mul_cnt;
    logic [rast_pkg::FILL_W-1:0] mul_val;
    logic [PW-1:0]               prod;
    logic [SPW-1:0]              sp_m1;
    logic [KW-1:0]               stk_top;
    logic                        out_go;

    assign in_lo        = POSW'(req.range_lo);
    assign in_hi        = POSW'(req.range_hi);
    assign in_bad       = (in_lo > in_hi) || (in_hi >= POSW'(N_LEAVES));
    assign in_root_full = (in_lo == '0) && (in_hi == POSW'(N_LEAVES - 1));
    assign accept       = req_valid && !req_stall;
    assign is_assign    = (func_reg == rast_pkg::FUNC_ASSIGN);

    assign cur_k = fr_k_reg[cur_reg];
    assign cur_s = fr_s_reg[cur_reg];
    assign cur_e = fr_e_reg[cur_reg];
    assign mid   = cur_s + ((cur_e - cur_s) >> 1);
    assign lk    = {cur_k[KW-2:0], 1'b0};
    assign rk    = {cur_k[KW-2:0], 1'b1};

    assign sp_m1   = sp_reg - 1'b1;
    assign stk_top = stk_reg[sp_m1[SIW-1:0]];

    // child under work: left, right, or the root itself
    always_comb
    begin
        ch_k  = cur_k;
        ch_s  = cur_s;
        ch_e  = cur_e;
        ch_in = rd_data;
        case (state_reg)
            rast_pkg::ST_WR_L:
            begin
                ch_k  = lk;
                ch_e  = mid;
                ch_in = l_reg;
            end
            rast_pkg::ST_WR_R:
            begin
                ch_k = rk;
                ch_s = mid + 1'b1;
            end
            default:
            begin
                ch_k = cur_k;
            end
        endcase
    end

    assign ch_full = (lo_reg <= ch_s) && (ch_e <= hi_reg);
    assign ch_over = !(ch_e < lo_reg) && !(ch_s > hi_reg);
    assign ch_part = ch_over && !ch_full;

    assign mul_cnt = ch_e - ch_s + 1'b1;
    assign mul_val = (ch_full && is_assign) ? v_reg : p_reg.fill;
    assign prod    = PW'(mul_cnt) * PW'(mul_val);

    always_comb
    begin
        if (ch_full && is_assign)
        begin
            ch_new = '{total: prod[rast_pkg::TOTAL_W-1:0], fill: v_reg, pend: 1'b1};
        end
        else if (p_reg.pend)
        begin
            ch_new = '{total: prod[rast_pkg::TOTAL_W-1:0], fill: p_reg.fill, pend: 1'b1};
        end
        else
        begin
            ch_new = ch_in;
        end
    end

    assign out_go = !done_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rast_pkg::ST_CLEAR:
            begin
                if (clr_reg == KW'(TREE_NODES - 1))
                begin
                    state_next = rast_pkg::ST_IDLE;
                end
            end
            rast_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (in_bad)
                    begin
                        state_next = rast_pkg::ST_DONE;
                    end
                    else if (in_root_full)
                    begin
                        state_next = rast_pkg::ST_ROOT_RD;
                    end
                    else
                    begin
                        state_next = rast_pkg::ST_RD_P;
                    end
                end
            end
            rast_pkg::ST_ROOT_RD:  state_next = rast_pkg::ST_ROOT_FIN;
            rast_pkg::ST_ROOT_FIN: state_next = rast_pkg::ST_DONE;
            rast_pkg::ST_RD_P:     state_next = rast_pkg::ST_RD_L;
            rast_pkg::ST_RD_L:     state_next = rast_pkg::ST_RD_R;
            rast_pkg::ST_RD_R:     state_next = rast_pkg::ST_WR_L;
            rast_pkg::ST_WR_L:     state_next = rast_pkg::ST_WR_R;
            rast_pkg::ST_WR_R:     state_next = rast_pkg::ST_WR_P;
            rast_pkg::ST_WR_P:
            begin
                if ((!cur_reg && fr_two_reg) || (nf_cnt_reg != 2'd0))
                begin
                    state_next = rast_pkg::ST_RD_P;
                end
                else if (is_assign)
                begin
                    state_next = rast_pkg::ST_UP_RL;
                end
                else
                begin
                    state_next = rast_pkg::ST_DONE;
                end
            end
            rast_pkg::ST_UP_RL: state_next = rast_pkg::ST_UP_RR;
            rast_pkg::ST_UP_RR: state_next = rast_pkg::ST_UP_WR;
            rast_pkg::ST_UP_WR:
            begin
                if (sp_reg == SPW'(1))
                begin
                    state_next = rast_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rast_pkg::ST_UP_RL;
                end
            end
            rast_pkg::ST_DONE:
            begin
                if (out_go)
                begin
                    state_next = rast_pkg::ST_IDLE;
                end
            end
            default: state_next = rast_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory port
    always_comb
    begin
        req_stall     = (state_reg != rast_pkg::ST_IDLE);
        done_valid    = (state_reg == rast_pkg::ST_DONE);
        done          = '{range_total: acc_reg, bad_range: bad_reg};
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        rd_addr       = cur_k;
        wr_addr       = ch_k;
        wr_data       = ch_new;
        case (state_reg)
            rast_pkg::ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = clr_reg;
                wr_data       = '0;
            end
            rast_pkg::ST_ROOT_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = KW'(1);
            end
            rast_pkg::ST_ROOT_FIN:
            begin
                mem_ctl.wr_en = is_assign;
                wr_addr       = KW'(1);
            end
            rast_pkg::ST_RD_P:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = cur_k;
            end
            rast_pkg::ST_RD_L:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = lk;
            end
            rast_pkg::ST_RD_R:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = rk;
            end
            rast_pkg::ST_WR_L, rast_pkg::ST_WR_R:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            rast_pkg::ST_WR_P:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = cur_k;
                wr_data       = '{total: p_reg.total, fill: p_reg.fill, pend: 1'b0};
            end
            rast_pkg::ST_UP_RL:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = {stk_top[KW-2:0], 1'b0};
            end
            rast_pkg::ST_UP_RR:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = {stk_top[KW-2:0], 1'b1};
            end
            rast_pkg::ST_UP_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = stk_top;
                wr_data       = '{total: l_reg.total + rd_data.total, fill: '0, pend: 1'b0};
            end
            default:
            begin
                mem_ctl.rd_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rast_pkg::ST_CLEAR;
            clr_reg    <= '0;
            sp_reg     <= '0;
            nf_cnt_reg <= '0;
            cur_reg    <= 1'b0;
            fr_two_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rast_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (accept)
            begin
                sp_reg     <= '0;
                nf_cnt_reg <= '0;
                cur_reg    <= 1'b0;
                fr_two_reg <= 1'b0;
            end
            if ((state_reg == rast_pkg::ST_WR_L || state_reg == rast_pkg::ST_WR_R) && ch_part)
            begin
                nf_cnt_reg <= nf_cnt_reg + 1'b1;
            end
            if (state_reg == rast_pkg::ST_WR_P)
            begin
                if (is_assign)
                begin
                    sp_reg <= sp_reg + 1'b1;
                end
                if (!cur_reg && fr_two_reg)
                begin
                    cur_reg <= 1'b1;
                end
                else if (nf_cnt_reg != 2'd0)
                begin
                    cur_reg    <= 1'b0;
                    fr_two_reg <= (nf_cnt_reg == 2'd2);
                    nf_cnt_reg <= '0;
                end
            end
            if (state_reg == rast_pkg::ST_UP_WR)
            begin
                sp_reg <= sp_m1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            lo_reg      <= in_lo;
            hi_reg      <= in_hi;
            v_reg       <= req.fill_value;
            bad_reg     <= in_bad;
            acc_reg     <= '0;
            fr_k_reg[0] <= KW'(1);
            fr_s_reg[0] <= '0;
            fr_e_reg[0] <= POSW'(N_LEAVES - 1);
        end
        if (state_reg == rast_pkg::ST_RD_L)
        begin
            p_reg <= rd_data;
        end
        if (state_reg == rast_pkg::ST_RD_R || state_reg == rast_pkg::ST_UP_RR)
        begin
            l_reg <= rd_data;
        end
        if (state_reg == rast_pkg::ST_ROOT_FIN && !is_assign)
        begin
            acc_reg <= rd_data.total;
        end
        if (state_reg == rast_pkg::ST_WR_L || state_reg == rast_pkg::ST_WR_R)
        begin
            if (ch_full && !is_assign)
            begin
                acc_reg <= acc_reg + ch_new.total;
            end
            if (ch_part)
            begin
                nf_k_reg[nf_cnt_reg[0]] <= ch_k;
                nf_s_reg[nf_cnt_reg[0]] <= ch_s;
                nf_e_reg[nf_cnt_reg[0]] <= ch_e;
            end
        end
        if (state_reg == rast_pkg::ST_WR_P)
        begin
            if (is_assign)
            begin
                stk_reg[sp_reg[SIW-1:0]] <= cur_k;
            end
            if (!(!cur_reg && fr_two_reg) && (nf_cnt_reg != 2'd0))
            begin
                fr_k_reg[0] <= nf_k_reg[0];
                fr_s_reg[0] <= nf_s_reg[0];
                fr_e_reg[0] <= nf_e_reg[0];
                fr_k_reg[1] <= nf_k_reg[1];
                fr_s_reg[1] <= nf_s_reg[1];
                fr_e_reg[1] <= nf_e_reg[1];
            end
        end
    end

    `RAST_ASSERT(a_stk_room, clk, rst_n, (state_reg == rast_pkg::ST_WR_P && is_assign) |-> (sp_reg < SPW'(STK_D)), "node stack overflow")
    `RAST_ASSERT(a_nf_room, clk, rst_n, ((state_reg == rast_pkg::ST_WR_L || state_reg == rast_pkg::ST_WR_R) && ch_part) |-> (nf_cnt_reg != 2'd2), "more than two straddling nodes on a level")
    `RAST_NEVER(a_no_wr_idle, clk, rst_n, (state_reg == rast_pkg::ST_IDLE) && mem_ctl.wr_en, "node write while idle")

endmodule

`default_nettype wire

### design/range_assign_range_sum_tree.sv
// flow: a rejected item goes straight to its result; a range covering every leaf reads the root
// and, for an assign, rewrites it; otherwise each straddling node (at most two per tree level)
// is read with both children, the children and the node are written back, and an assign then
// re-sums each visited node on the way back up. One item at a time, taken only when idle.
// reset: a sweep over all 4*N_LEAVES nodes zeroes the node memory; no item is taken meanwhile.
`default_nettype none

module range_assign_range_sum_tree #(
    parameter int N_LEAVES = rast_pkg::N_LEAVES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire rast_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output rast_pkg::rsp_t      rsp
);

    localparam int TREE_NODES = 4 * N_LEAVES;
    localparam int KW         = $clog2(TREE_NODES);

    rast_pkg::mem_ctl_t mem_ctl;
    logic [KW-1:0]      rd_addr;
    logic [KW-1:0]      wr_addr;
    rast_pkg::node_t    wr_data;
    rast_pkg::node_t    rd_data;

    logic               done_valid;
    logic               done_stall;
    rast_pkg::rsp_t     done;

    logic               out_valid_reg, out_valid_next;
    rast_pkg::rsp_t     out_reg;
    logic               load;

    rast_node_mem #(
        .DEPTH (TREE_NODES),
        .AW    (KW)
    ) u_mem (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    rast_walk #(
        .N_LEAVES (N_LEAVES),
        .KW       (KW)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .done_valid (done_valid),
        .done_stall (done_stall),
        .done       (done),
        .mem_ctl    (mem_ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_data    (rd_data)
    );

    // result beat register
    assign done_stall     = out_valid_reg && rsp_stall;
    assign load           = done_valid && !done_stall;
    assign out_valid_next = load || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= done;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
